// ----- rtl/baro_pkg.sv -----
package baro_pkg;

	// Pipeline depth from input register to output register
	localparam int NUM_STAGES = 17;

	// Calibration register indices on the write port
	typedef enum logic [2:0] {
		REG_SENS     = 3'd0,
		REG_OFF      = 3'd1,
		REG_TCS      = 3'd2,
		REG_TCO      = 3'd3,
		REG_TREF     = 3'd4,
		REG_TEMPSENS = 3'd5
	} coef_reg_t;

	// 20.00 C reference and the distance from it down to -15.00 C
	localparam logic signed [18:0] TEMP_REF = 19'sd2000;
	localparam logic signed [18:0] COLD_OFS = 19'sd3500;

	// Pa to mmHg Q8: 256 * 750.0617 / 100000 reduced to 7500617 / 3906250
	localparam logic [22:0] MMHG_NUM   = 23'd7500617;
	localparam logic [21:0] MMHG_DEN   = 22'd3906250;
	localparam logic [21:0] MMHG_HALF  = 22'd1953125;
	// floor(2^46 / MMHG_DEN), estimate is at most one below the true quotient
	localparam logic [24:0] MMHG_RECIP = 25'd18014398;

	// Q8 saturation magnitudes
	localparam logic [24:0] Q8_POS_MAX = 25'd8388607;
	localparam logic [24:0] Q8_NEG_MAX = 25'd8388608;

endpackage

// ----- rtl/baro_pressure_compensation.sv -----
// Second-order compensated barometric pressure. Each transfer on the input
// channel carries one raw pressure and one raw temperature conversion and
// yields exactly one result: pressure in pascals, pressure in mmHg as Q8
// (rounded to nearest, ties away from zero) and first-order temperature in
// hundredths of a degree, each saturated to its width. The datapath is a
// 17-stage pipeline: a pair can be taken in every cycle while in_stall is
// low. A stalled output only holds the stages that are full; empty stages
// keep filling, and in_stall rises once the whole pipeline is occupied. The
// six calibration words are written through wr_en/wr_index/wr_data, reset
// to zero, and should only change while the pipeline is empty; writes to
// unused indices are dropped.
module baro_pressure_compensation (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [2:0]         wr_index,
	input  logic [15:0]        wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [23:0]        raw_pressure,
	input  logic [23:0]        raw_temperature,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] pressure_pa,
	output logic signed [23:0] pressure_mmhg_q8,
	output logic signed [15:0] temperature_centideg
);

	localparam int NS = baro_pkg::NUM_STAGES;

	// ------------------------------------------------------------------
	// Calibration registers
	// ------------------------------------------------------------------
	logic [15:0] coef_sens_q, coef_off_q, coef_tcs_q, coef_tco_q;
	logic [15:0] coef_tref_q, coef_tempsens_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_sens_q     <= '0;
			coef_off_q      <= '0;
			coef_tcs_q      <= '0;
			coef_tco_q      <= '0;
			coef_tref_q     <= '0;
			coef_tempsens_q <= '0;
		end else if (wr_en) begin
			unique case (baro_pkg::coef_reg_t'(wr_index))
				baro_pkg::REG_SENS:     coef_sens_q     <= wr_data;
				baro_pkg::REG_OFF:      coef_off_q      <= wr_data;
				baro_pkg::REG_TCS:      coef_tcs_q      <= wr_data;
				baro_pkg::REG_TCO:      coef_tco_q      <= wr_data;
				baro_pkg::REG_TREF:     coef_tref_q     <= wr_data;
				baro_pkg::REG_TEMPSENS: coef_tempsens_q <= wr_data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Stage valids and per-stage advance
	// ------------------------------------------------------------------
	logic [NS:1] vld_q;
	logic [NS:1] rdy;

	// A stage may load when it is empty or its successor moves on
	always_comb begin
		rdy[NS] = !vld_q[NS] || !out_stall;
		for (int k = NS - 1; k >= 1; k--) begin
			rdy[k] = !vld_q[k] || rdy[k + 1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= (vld_q & ~rdy) | ({vld_q[NS-1:1], in_valid} & rdy);
		end
	end

	assign in_stall  = !rdy[1];
	assign out_valid = vld_q[NS];

	// ------------------------------------------------------------------
	// Stage 1: temperature difference dT
	// ------------------------------------------------------------------
	logic        [23:0] d1_s1;
	logic signed [24:0] dt_s1;

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			d1_s1 <= raw_pressure;
			dt_s1 <= $signed({1'b0, raw_temperature}) - $signed({1'b0, coef_tref_q, 8'h00});
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: dT times the three temperature coefficients
	// ------------------------------------------------------------------
	logic        [23:0] d1_s2;
	logic signed [41:0] prod_t_s2, prod_o_s2, prod_s_s2;

	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			d1_s2     <= d1_s1;
			prod_t_s2 <= dt_s1 * $signed({1'b0, coef_tempsens_q});
			prod_o_s2 <= dt_s1 * $signed({1'b0, coef_tco_q});
			prod_s_s2 <= dt_s1 * $signed({1'b0, coef_tcs_q});
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: TEMP, OFF and SENS (divisions truncate toward zero)
	// ------------------------------------------------------------------
	logic signed [41:0] t_div, o_div, s_div;
	logic        [23:0] d1_s3;
	logic signed [18:0] dtemp_s3, cold_s3, temp_s3;
	logic signed [39:0] off_s3, sens_s3;

	always_comb begin
		t_div = (prod_t_s2 + (prod_t_s2[41] ? 42'sd8388607 : 42'sd0)) >>> 23;
		o_div = (prod_o_s2 + (prod_o_s2[41] ? 42'sd127 : 42'sd0)) >>> 7;
		s_div = (prod_s_s2 + (prod_s_s2[41] ? 42'sd255 : 42'sd0)) >>> 8;
	end

	always_ff @(posedge clk) begin
		if (rdy[3]) begin
			d1_s3    <= d1_s2;
			dtemp_s3 <= t_div[18:0];
			cold_s3  <= t_div[18:0] + baro_pkg::COLD_OFS;
			temp_s3  <= t_div[18:0] + baro_pkg::TEMP_REF;
			off_s3   <= $signed({8'h00, coef_off_q, 16'h0000}) + o_div[39:0];
			sens_s3  <= $signed({9'h000, coef_sens_q, 15'h0000}) + s_div[39:0];
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: squares for the low-temperature corrections
	// ------------------------------------------------------------------
	logic signed [37:0] a_sq, b_sq;
	logic        [23:0] d1_s4;
	logic        [34:0] a_sq_s4, b_sq_s4;
	logic               below20_s4, below15_s4;
	logic signed [39:0] off_s4, sens_s4;
	logic signed [15:0] temp_s4;

	always_comb begin
		a_sq = dtemp_s3 * dtemp_s3;
		b_sq = cold_s3 * cold_s3;
	end

	always_ff @(posedge clk) begin
		if (rdy[4]) begin
			d1_s4      <= d1_s3;
			a_sq_s4    <= a_sq[34:0];
			b_sq_s4    <= b_sq[34:0];
			below20_s4 <= dtemp_s3[18];
			below15_s4 <= cold_s3[18];
			off_s4     <= off_s3;
			sens_s4    <= sens_s3;
			if (temp_s3 > 19'sd32767) begin
				temp_s4 <= 16'sh7fff;
			end else if (temp_s3 < -19'sd32768) begin
				temp_s4 <= 16'sh8000;
			end else begin
				temp_s4 <= temp_s3[15:0];
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: OFF2 and SENS2
	// ------------------------------------------------------------------
	logic [39:0] a40, b40;
	logic [39:0] off2_nxt, sens2_nxt;
	logic        [23:0] d1_s5;
	logic        [39:0] off2_s5, sens2_s5;
	logic signed [39:0] off_s5, sens_s5;
	logic signed [15:0] temp_s5;

	always_comb begin
		a40       = {5'b0, a_sq_s4};
		b40       = {5'b0, b_sq_s4};
		off2_nxt  = (below20_s4 ? ((a40 * 40'd5) >> 1) : 40'd0)
		          + (below15_s4 ? (b40 * 40'd7) : 40'd0);
		sens2_nxt = (below20_s4 ? ((a40 * 40'd5) >> 2) : 40'd0)
		          + (below15_s4 ? ((b40 * 40'd11) >> 1) : 40'd0);
	end

	always_ff @(posedge clk) begin
		if (rdy[5]) begin
			d1_s5    <= d1_s4;
			off2_s5  <= off2_nxt;
			sens2_s5 <= sens2_nxt;
			off_s5   <= off_s4;
			sens_s5  <= sens_s4;
			temp_s5  <= temp_s4;
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: apply the corrections
	// ------------------------------------------------------------------
	logic        [23:0] d1_s6;
	logic signed [39:0] off_f_s6, sens_f_s6;
	logic signed [15:0] temp_s6;

	always_ff @(posedge clk) begin
		if (rdy[6]) begin
			d1_s6     <= d1_s5;
			off_f_s6  <= off_s5 - $signed(off2_s5);
			sens_f_s6 <= sens_s5 - $signed(sens2_s5);
			temp_s6   <= temp_s5;
		end
	end

	// ------------------------------------------------------------------
	// Stage 7: D1 * SENS as two partial products
	// ------------------------------------------------------------------
	logic        [43:0] pp_lo_s7;
	logic signed [44:0] pp_hi_s7;
	logic signed [39:0] off_f_s7;
	logic signed [15:0] temp_s7;

	always_ff @(posedge clk) begin
		if (rdy[7]) begin
			pp_lo_s7 <= d1_s6 * sens_f_s6[19:0];
			pp_hi_s7 <= $signed({1'b0, d1_s6}) * $signed(sens_f_s6[39:20]);
			off_f_s7 <= off_f_s6;
			temp_s7  <= temp_s6;
		end
	end

	// ------------------------------------------------------------------
	// Stage 8: combine the partial products
	// ------------------------------------------------------------------
	logic signed [63:0] prod_s8;
	logic signed [39:0] off_f_s8;
	logic signed [15:0] temp_s8;

	always_ff @(posedge clk) begin
		if (rdy[8]) begin
			prod_s8  <= $signed({pp_hi_s7[43:0], 20'h00000}) + $signed({20'h00000, pp_lo_s7});
			off_f_s8 <= off_f_s7;
			temp_s8  <= temp_s7;
		end
	end

	// ------------------------------------------------------------------
	// Stage 9: divide by 2^21 toward zero
	// ------------------------------------------------------------------
	logic signed [63:0] prod_div;
	logic signed [42:0] t_s9;
	logic signed [39:0] off_f_s9;
	logic signed [15:0] temp_s9;

	assign prod_div = (prod_s8 + (prod_s8[63] ? 64'sd2097151 : 64'sd0)) >>> 21;

	always_ff @(posedge clk) begin
		if (rdy[9]) begin
			t_s9     <= prod_div[42:0];
			off_f_s9 <= off_f_s8;
			temp_s9  <= temp_s8;
		end
	end

	// ------------------------------------------------------------------
	// Stage 10: subtract OFF
	// ------------------------------------------------------------------
	logic signed [43:0] u_s10;
	logic signed [15:0] temp_s10;

	always_ff @(posedge clk) begin
		if (rdy[10]) begin
			u_s10    <= $signed({t_s9[42], t_s9}) - $signed({{4{off_f_s9[39]}}, off_f_s9});
			temp_s10 <= temp_s9;
		end
	end

	// ------------------------------------------------------------------
	// Stage 11: divide by 2^15 toward zero, giving P
	// ------------------------------------------------------------------
	logic signed [43:0] u_div;
	logic signed [28:0] p_s11;
	logic signed [15:0] temp_s11;

	assign u_div = (u_s10 + (u_s10[43] ? 44'sd32767 : 44'sd0)) >>> 15;

	always_ff @(posedge clk) begin
		if (rdy[11]) begin
			p_s11    <= u_div[28:0];
			temp_s11 <= temp_s10;
		end
	end

	// ------------------------------------------------------------------
	// Stage 12: sign and magnitude of P
	// ------------------------------------------------------------------
	logic        [28:0] mag_full;
	logic        [22:0] mag_s12;
	logic               neg_s12, big_s12;
	logic signed [31:0] pa_s12;
	logic signed [15:0] temp_s12;

	assign mag_full = p_s11[28] ? (~p_s11 + 29'd1) : p_s11;

	always_ff @(posedge clk) begin
		if (rdy[12]) begin
			mag_s12  <= mag_full[22:0];
			neg_s12  <= p_s11[28];
			big_s12  <= |mag_full[28:23];
			pa_s12   <= {{3{p_s11[28]}}, p_s11};
			temp_s12 <= temp_s11;
		end
	end

	// ------------------------------------------------------------------
	// Stage 13: scaled magnitude plus half divisor for rounding
	// ------------------------------------------------------------------
	logic        [45:0] x_s13;
	logic               neg_s13, big_s13;
	logic signed [31:0] pa_s13;
	logic signed [15:0] temp_s13;

	always_ff @(posedge clk) begin
		if (rdy[13]) begin
			x_s13    <= mag_s12 * baro_pkg::MMHG_NUM + {24'h000000, baro_pkg::MMHG_HALF};
			neg_s13  <= neg_s12;
			big_s13  <= big_s12;
			pa_s13   <= pa_s12;
			temp_s13 <= temp_s12;
		end
	end

	// ------------------------------------------------------------------
	// Stage 14: quotient estimate by reciprocal
	// ------------------------------------------------------------------
	logic        [56:0] q_est;
	logic        [24:0] q_est_s14;
	logic        [22:0] x_lo_s14;
	logic               neg_s14, big_s14;
	logic signed [31:0] pa_s14;
	logic signed [15:0] temp_s14;

	assign q_est = x_s13[45:14] * baro_pkg::MMHG_RECIP;

	always_ff @(posedge clk) begin
		if (rdy[14]) begin
			q_est_s14 <= q_est[56:32];
			x_lo_s14  <= x_s13[22:0];
			neg_s14   <= neg_s13;
			big_s14   <= big_s13;
			pa_s14    <= pa_s13;
			temp_s14  <= temp_s13;
		end
	end

	// ------------------------------------------------------------------
	// Stage 15: back-multiply the estimate (remainder fits in 23 bits)
	// ------------------------------------------------------------------
	logic        [46:0] qd;
	logic        [22:0] qd_lo_s15, x_lo_s15;
	logic        [24:0] q_est_s15;
	logic               neg_s15, big_s15;
	logic signed [31:0] pa_s15;
	logic signed [15:0] temp_s15;

	assign qd = q_est_s14 * baro_pkg::MMHG_DEN;

	always_ff @(posedge clk) begin
		if (rdy[15]) begin
			qd_lo_s15 <= qd[22:0];
			x_lo_s15  <= x_lo_s14;
			q_est_s15 <= q_est_s14;
			neg_s15   <= neg_s14;
			big_s15   <= big_s14;
			pa_s15    <= pa_s14;
			temp_s15  <= temp_s14;
		end
	end

	// ------------------------------------------------------------------
	// Stage 16: correct the estimate by one where the remainder allows
	// ------------------------------------------------------------------
	logic        [22:0] rem;
	logic        [24:0] q_s16;
	logic               neg_s16, big_s16;
	logic signed [31:0] pa_s16;
	logic signed [15:0] temp_s16;

	assign rem = x_lo_s15 - qd_lo_s15;

	always_ff @(posedge clk) begin
		if (rdy[16]) begin
			q_s16    <= q_est_s15 + {24'h000000, (rem >= {1'b0, baro_pkg::MMHG_DEN})};
			neg_s16  <= neg_s15;
			big_s16  <= big_s15;
			pa_s16   <= pa_s15;
			temp_s16 <= temp_s15;
		end
	end

	// ------------------------------------------------------------------
	// Stage 17: sign, saturate and hold for the output transfer
	// ------------------------------------------------------------------
	logic [24:0] q_neg;

	assign q_neg = ~q_s16 + 25'd1;

	always_ff @(posedge clk) begin
		if (rdy[17]) begin
			pressure_pa          <= pa_s16;
			temperature_centideg <= temp_s16;
			if (neg_s16) begin
				if (big_s16 || q_s16 >= baro_pkg::Q8_NEG_MAX) begin
					pressure_mmhg_q8 <= 24'sh800000;
				end else begin
					pressure_mmhg_q8 <= q_neg[23:0];
				end
			end else begin
				if (big_s16 || q_s16 >= baro_pkg::Q8_POS_MAX) begin
					pressure_mmhg_q8 <= 24'sh7fffff;
				end else begin
					pressure_mmhg_q8 <= q_s16[23:0];
				end
			end
		end
	end

endmodule

// ----- tb/tb_baro_pressure_compensation.sv -----
module tb_baro_pressure_compensation;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam logic [23:0] RAW_MAX = 24'hFFFFFF;
	localparam logic [15:0] COEF_MAX = 16'hFFFF;
	// Indices past the last calibration word: writes there must be dropped
	localparam logic [2:0] REG_SPARE_LO = 3'd6;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;

	typedef struct packed {
		logic signed [31:0] pa;
		logic signed [23:0] mmhg_q8;
		logic signed [15:0] centideg;
	} pressure_reading_t;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [2:0] wr_index;
	logic [15:0] wr_data;
	logic in_valid;
	logic in_stall;
	logic [23:0] raw_pressure;
	logic [23:0] raw_temperature;
	logic out_valid;
	logic out_stall;
	logic signed [31:0] pressure_pa;
	logic signed [23:0] pressure_mmhg_q8;
	logic signed [15:0] temperature_centideg;

	// Local copy of the calibration words
	logic [15:0] cal_sens, cal_off, cal_tcs, cal_tco, cal_tref, cal_tempsens;

	pressure_reading_t expected_readings[$];
	int idle_pct;
	int stall_pct;
	int mismatch_count;
	int pairs_sent;
	int readings_checked;
	int coef_sets;

	baro_pressure_compensation i_dut (
		.clk                  (clk),
		.arst_n               (arst_n),
		.wr_en                (wr_en),
		.wr_index             (wr_index),
		.wr_data              (wr_data),
		.in_valid             (in_valid),
		.in_stall             (in_stall),
		.raw_pressure         (raw_pressure),
		.raw_temperature      (raw_temperature),
		.out_valid            (out_valid),
		.out_stall            (out_stall),
		.pressure_pa          (pressure_pa),
		.pressure_mmhg_q8     (pressure_mmhg_q8),
		.temperature_centideg (temperature_centideg)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Second-order compensation of one conversion pair, all in 64-bit integers
	function automatic pressure_reading_t compensate(input logic [23:0] d1_raw,
			input logic [23:0] d2_raw);
		longint d1, d2, c1, c2, c3, c4, c5, c6;
		longint dt, temp, off, sens, off2, sens2, a, b, p, q8;
		longint unsigned mag, qmag;
		pressure_reading_t r;
		d1 = d1_raw;
		d2 = d2_raw;
		c1 = cal_sens;
		c2 = cal_off;
		c3 = cal_tcs;
		c4 = cal_tco;
		c5 = cal_tref;
		c6 = cal_tempsens;
		dt = d2 - c5 * 256;
		temp = 2000 + (dt * c6) / 8388608;
		off = c2 * 65536 + (c4 * dt) / 128;
		sens = c1 * 32768 + (c3 * dt) / 256;
		off2 = 0;
		sens2 = 0;
		// below 20.00 C
		if (temp < 2000) begin
			a = temp - 2000;
			off2 = 5 * a * a / 2;
			sens2 = 5 * a * a / 4;
		end
		// further correction below -15.00 C
		if (temp < -1500) begin
			b = temp + 1500;
			off2 = off2 + 7 * b * b;
			sens2 = sens2 + 11 * b * b / 2;
		end
		off = off - off2;
		sens = sens - sens2;
		p = (d1 * sens / 2097152 - off) / 32768;
		// mmHg Q8, round half away from zero on the magnitude
		mag = (p < 0) ? longint'(-p) : longint'(p);
		qmag = (mag * 64'd1920157952 + 64'd500000000) / 64'd1000000000;
		if (qmag > 64'd8388608)
			qmag = 64'd8388608;
		q8 = (p < 0) ? -longint'(qmag) : longint'(qmag);
		if (q8 > 64'sd8388607)
			q8 = 64'sd8388607;
		if (p > 64'sd2147483647)
			p = 64'sd2147483647;
		if (p < -64'sd2147483648)
			p = -64'sd2147483648;
		if (temp > 64'sd32767)
			temp = 64'sd32767;
		if (temp < -64'sd32768)
			temp = -64'sd32768;
		r.pa = p[31:0];
		r.mmhg_q8 = q8[23:0];
		r.centideg = temp[15:0];
		return r;
	endfunction

	// Write one register, then wait with wr_en low so it is never re-driven in a step
	task automatic write_coef(input logic [2:0] idx, input logic [15:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			baro_pkg::REG_SENS: cal_sens = val;
			baro_pkg::REG_OFF: cal_off = val;
			baro_pkg::REG_TCS: cal_tcs = val;
			baro_pkg::REG_TCO: cal_tco = val;
			baro_pkg::REG_TREF: cal_tref = val;
			baro_pkg::REG_TEMPSENS: cal_tempsens = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic load_coefs(input logic [15:0] sens, off, tcs, tco, tref, tempsens);
		write_coef(baro_pkg::REG_SENS, sens);
		write_coef(baro_pkg::REG_OFF, off);
		write_coef(baro_pkg::REG_TCS, tcs);
		write_coef(baro_pkg::REG_TCO, tco);
		write_coef(baro_pkg::REG_TREF, tref);
		write_coef(baro_pkg::REG_TEMPSENS, tempsens);
		coef_sets++;
	endtask

	// Offer one conversion pair, hold it until the transfer, then record the expectation
	task automatic send_pair(input logic [23:0] d1, input logic [23:0] d2);
		if ($urandom_range(1, 100) <= idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid <= 1'b1;
		raw_pressure <= d1;
		raw_temperature <= d2;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		expected_readings.push_back(compensate(d1, d2));
		pairs_sent++;
	endtask

	// Stop offering and wait until the pipeline has handed back everything
	task automatic drain;
		in_valid <= 1'b0;
		while (expected_readings.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	function automatic logic [15:0] rand_coef;
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return COEF_MAX;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic test_reset_coefs;
		send_pair(24'd0, 24'd0);
		send_pair(RAW_MAX, RAW_MAX);
		send_pair(RAW_MAX, 24'd0);
		drain();
	endtask

	// Typical calibration; C6 = 2^15 puts TEMP at 2000 + dT/256, so bands are hit exactly
	task automatic test_temperature_bands;
		logic [23:0] base;
		load_coefs(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd32768);
		base = 24'(cal_tref) << 8;
		send_pair(24'd9085466, base);
		send_pair(24'd9085466, base + 24'd384000);
		// small negative dT truncates toward zero, not down
		send_pair(24'd9085466, base - 24'd1);
		send_pair(24'd9085466, base - 24'd255);
		send_pair(24'd9085466, base - 24'd256);
		// -15.00 C exactly, then one step below it
		send_pair(24'd9085466, base - 24'd896000);
		send_pair(24'd9085466, base - 24'd896256);
		send_pair(24'd9085466, 24'd0);
		send_pair(24'd9085466, RAW_MAX);
		send_pair(24'd0, base);
		send_pair(RAW_MAX, base);
		drain();
	endtask

	task automatic test_saturation;
		load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
		send_pair(24'd0, 24'd0);
		send_pair(RAW_MAX, 24'd0);
		send_pair(RAW_MAX, RAW_MAX);
		send_pair(24'd0, RAW_MAX);
		drain();
		load_coefs(COEF_MAX, 16'h0000, COEF_MAX, 16'h0000, 16'h0000, COEF_MAX);
		send_pair(RAW_MAX, RAW_MAX);
		drain();
		load_coefs(16'h0000, COEF_MAX, 16'h0000, COEF_MAX, COEF_MAX, 16'h0000);
		send_pair(RAW_MAX, 24'd0);
		drain();
	endtask

	task automatic test_unused_index;
		write_coef(REG_SPARE_LO, COEF_MAX);
		write_coef(REG_SPARE_HI, 16'h0000);
		send_pair(24'd8000000, 24'd8000000);
		send_pair(24'd123456, 24'd0);
		drain();
	endtask

	// Random calibration per phase; half the pairs sit near the reference temperature
	task automatic test_random_traffic(input int phases, input int per_phase, input bit bursty);
		longint d2;
		logic [23:0] d1;
		for (int ph = 0; ph < phases; ph++) begin
			idle_pct = 0;
			stall_pct = 0;
			if (bursty) begin
				case ($urandom_range(0, 3))
					0: idle_pct = 0;
					1: idle_pct = 5;
					2: idle_pct = 20;
					default: idle_pct = 50;
				endcase
				case ($urandom_range(0, 3))
					0: stall_pct = 0;
					1: stall_pct = 5;
					2: stall_pct = 20;
					default: stall_pct = 50;
				endcase
			end
			load_coefs(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(),
				rand_coef());
			for (int n = 0; n < per_phase; n++) begin
				d1 = 24'($urandom);
				if ($urandom_range(0, 15) == 0)
					d1 = $urandom_range(0, 1) ? RAW_MAX : 24'd0;
				if ($urandom_range(0, 1) == 0) begin
					d2 = 24'($urandom);
				end else begin
					d2 = longint'(cal_tref) * 256 + longint'($urandom_range(0, 2097152))
						- 1048576;
					if (d2 < 0)
						d2 = 0;
					if (d2 > 64'sd16777215)
						d2 = 64'sd16777215;
				end
				send_pair(d1, d2[23:0]);
			end
			drain();
		end
	endtask

	// Receiver: random stall bursts
	initial begin
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ($urandom_range(1, 100) <= stall_pct) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Check each result transfer against the oldest expectation
	always @(posedge clk) begin
		pressure_reading_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_readings.size() == 0) begin
				$error("result with no pair pending: pa %0d mmhg_q8 %0d centideg %0d",
					pressure_pa, pressure_mmhg_q8, temperature_centideg);
				mismatch_count++;
			end else begin
				want = expected_readings.pop_front();
				readings_checked++;
				if (pressure_pa !== want.pa) begin
					$error("pressure_pa: expected %0d, got %0d", want.pa, pressure_pa);
					mismatch_count++;
				end
				if (pressure_mmhg_q8 !== want.mmhg_q8) begin
					$error("pressure_mmhg_q8: expected %0d, got %0d", want.mmhg_q8,
						pressure_mmhg_q8);
					mismatch_count++;
				end
				if (temperature_centideg !== want.centideg) begin
					$error("temperature_centideg: expected %0d, got %0d", want.centideg,
						temperature_centideg);
					mismatch_count++;
				end
			end
		end
	end

	// Abort when no transfer happens on either channel for too long
	initial begin
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$error("no transfer for %0d cycles", WATCHDOG_LIMIT);
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		wr_en <= 1'b0;
		wr_index <= baro_pkg::REG_SENS;
		wr_data <= 16'h0000;
		in_valid <= 1'b0;
		raw_pressure <= 24'd0;
		raw_temperature <= 24'd0;
		cal_sens = 16'h0000;
		cal_off = 16'h0000;
		cal_tcs = 16'h0000;
		cal_tco = 16'h0000;
		cal_tref = 16'h0000;
		cal_tempsens = 16'h0000;
		idle_pct = 0;
		stall_pct = 0;
		mismatch_count = 0;
		pairs_sent = 0;
		readings_checked = 0;
		coef_sets = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_coefs();
		test_temperature_bands();
		test_saturation();
		test_unused_index();
		test_random_traffic(9, 105, 1'b1);
		test_random_traffic(1, 105, 1'b0);

		repeat (baro_pkg::NUM_STAGES + 8) @(posedge clk);
		$display("%0d conversion pairs sent, %0d results checked over %0d calibration sets",
			pairs_sent, readings_checked, coef_sets);
		$display("covered reset calibration, all temperature bands and their edges, %s",
			"saturation, spare register indices, bursty and full-rate traffic");
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/baro_pkg.sv
rtl/baro_pressure_compensation.sv
tb/tb_baro_pressure_compensation.sv
